@@ rtl/tac_pkg.sv @@
// Shared constants, widths and control types of the thermistor conversion pipeline.
package tac_pkg;

	localparam int ADC_BITS_DEF = 10;

	localparam int COEF_W     = 48;
	localparam int SR_W       = 24;
	localparam int TEMP_W     = 18;
	localparam int STATUS_W   = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;

	localparam logic [CFG_IDX_W-1:0] REG_COEF_A       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_B       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_C       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SERIES_RES   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_TEMP = 3'd4;

	localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_RAIL = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_SAT  = 2'd2;

	localparam logic [COEF_W-1:0] COEF_A_RST       = 48'd309566976000;
	localparam logic [COEF_W-1:0] COEF_B_RST       = 48'd67554994176;
	localparam logic [COEF_W-1:0] COEF_C_RST       = 48'd1291272085;
	localparam logic [SR_W-1:0]   SERIES_RES_RST   = 24'd10000;
	localparam logic [TEMP_W-1:0] DEFAULT_TEMP_RST = 18'd6400;

	// natural log unit: Q30 mantissa, 32 squaring steps, Q32 result
	localparam int LN_KW    = 5;
	localparam int LN_M_W   = 31;
	localparam int LN_STEPS = 32;
	localparam int LN_W     = 37;
	localparam logic [31:0] LN2_Q32 = 32'd2977044472;
	localparam int LN_LAT   = LN_STEPS + 3;

	// wide multiplier: operands split at 32 bits, partial products then sum
	localparam int MUL_SPLIT = 32;
	localparam int MUL_LAT   = 2;

	localparam int Y_W    = 38;
	localparam int YM_W   = 37;
	localparam int Y2_W   = 42;
	localparam int Y3_W   = 47;
	localparam int PB_W   = 61;
	localparam int PC_W   = 55;
	localparam int INV_W  = 63;
	localparam int INVM_W = 62;

	// reciprocal: floor(2^72 / m) for m >= 2^32, one quotient bit per stage
	localparam int DIV_NUM_EXP = 72;
	localparam int DIV_Q_W     = 41;

	localparam int ZERO_C_Q16 = 17901158;
	localparam int T16_W      = 43;
	localparam int T8_W       = 35;
	localparam int TEMP_MAX_V = 131071;
	localparam int TEMP_MIN_V = -131072;

	typedef struct packed {
		logic valid;
		logic rail;
	} front_ctl_t;

	typedef struct packed {
		logic valid;
		logic rail;
		logic neg;
		logic tiny;
	} back_ctl_t;

endpackage

@@ rtl/tac_code_if.sv @@
// Input channel: one raw divider converter code per item.
interface tac_code_if import tac_pkg::*; #(parameter int ADC_BITS = ADC_BITS_DEF);
	logic                valid;
	logic                ready;
	logic [ADC_BITS-1:0] adc_code;

	modport source (output valid, output adc_code, input ready);
	modport sink (input valid, input adc_code, output ready);
endinterface

@@ rtl/tac_temp_if.sv @@
// Output channel: temperature and status per item.
interface tac_temp_if import tac_pkg::*;;
	logic                       valid;
	logic                       ready;
	logic signed [TEMP_W-1:0]   temperature;
	logic        [STATUS_W-1:0] status;

	modport source (output valid, output temperature, output status, input ready);
	modport sink (input valid, input temperature, input status, output ready);
endinterface

@@ rtl/tac_delay.sv @@
// Enabled delay line of fixed length.
module tac_delay import tac_pkg::*; #(
	parameter int W = 1,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] pipe_s [N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) pipe_s[i] <= '0;
		end else if (en) begin
			pipe_s[0] <= d;
			for (int i = 1; i < N; i++) pipe_s[i] <= pipe_s[i-1];
		end
	end

	assign q = pipe_s[N-1];

endmodule

@@ rtl/tac_mul.sv @@
// Unsigned wide multiplier: four partial products, then their sum.
module tac_mul import tac_pkg::*; #(
	parameter int WA = 48,
	parameter int WB = 48
) (
	input  logic             clk,
	input  logic             en,
	input  logic [WA-1:0]    a,
	input  logic [WB-1:0]    b,
	output logic [WA+WB-1:0] p
);

	localparam int HA = WA - MUL_SPLIT;
	localparam int HB = WB - MUL_SPLIT;
	localparam int PW = WA + WB;

	logic [2*MUL_SPLIT-1:0] ll_s1;
	logic [MUL_SPLIT+HB-1:0] lh_s1;
	logic [HA+MUL_SPLIT-1:0] hl_s1;
	logic [HA+HB-1:0]        hh_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= (2*MUL_SPLIT)'(a[MUL_SPLIT-1:0]) * (2*MUL_SPLIT)'(b[MUL_SPLIT-1:0]);
			lh_s1 <= (MUL_SPLIT+HB)'(a[MUL_SPLIT-1:0]) * (MUL_SPLIT+HB)'(b[WB-1:MUL_SPLIT]);
			hl_s1 <= (HA+MUL_SPLIT)'(a[WA-1:MUL_SPLIT]) * (HA+MUL_SPLIT)'(b[MUL_SPLIT-1:0]);
			hh_s1 <= (HA+HB)'(a[WA-1:MUL_SPLIT]) * (HA+HB)'(b[WB-1:MUL_SPLIT]);
			p     <= PW'(ll_s1) + (PW'(lh_s1) << MUL_SPLIT) + (PW'(hl_s1) << MUL_SPLIT)
				+ (PW'(hh_s1) << (2*MUL_SPLIT));
		end
	end

endmodule

@@ rtl/tac_ln.sv @@
// Natural log in Q32 of a positive integer by normalization and repeated squaring.
module tac_ln import tac_pkg::*; #(
	parameter int IN_W = SR_W
) (
	input  logic            clk,
	input  logic            en,
	input  logic [IN_W-1:0] x,
	output logic [LN_W-1:0] ln
);

	logic [LN_KW-1:0]  k_norm;
	logic [LN_M_W-1:0] m_norm;

	logic [LN_M_W-1:0]   m_s    [LN_STEPS+1];
	logic [LN_STEPS-1:0] frac_s [LN_STEPS+1];
	logic [LN_KW-1:0]    k_s    [LN_STEPS+1];

	logic [63:0]      prod_s;
	logic [LN_KW-1:0] kp_s;

	// leading one gives the exponent; shift the mantissa into Q30
	always_comb begin
		k_norm = '0;
		for (int i = 0; i < IN_W; i++) begin
			if (x[i]) k_norm = LN_KW'(i);
		end
		m_norm = LN_M_W'(x) << (LN_KW'(LN_M_W - 1) - k_norm);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s[0]    <= m_norm;
			frac_s[0] <= '0;
			k_s[0]    <= k_norm;
		end
	end

	for (genvar g = 0; g < LN_STEPS; g++) begin : g_sq
		logic [2*LN_M_W-1:0] sq;
		logic [LN_M_W:0]     sq_sh;

		assign sq    = (2*LN_M_W)'(m_s[g]) * (2*LN_M_W)'(m_s[g]);
		assign sq_sh = sq[LN_M_W-1 +: LN_M_W+1];

		// square, and halve when it reaches two: that step yields a one bit
		always_ff @(posedge clk) begin
			if (en) begin
				k_s[g+1] <= k_s[g];
				if (sq_sh[LN_M_W]) begin
					m_s[g+1]    <= sq_sh[LN_M_W:1];
					frac_s[g+1] <= {frac_s[g][LN_STEPS-2:0], 1'b1};
				end else begin
					m_s[g+1]    <= sq_sh[LN_M_W-1:0];
					frac_s[g+1] <= {frac_s[g][LN_STEPS-2:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s <= 64'(frac_s[LN_STEPS]) * 64'(LN2_Q32);
			kp_s   <= k_s[LN_STEPS];
			ln     <= LN_W'(kp_s) * LN_W'(LN2_Q32) + LN_W'(prod_s[63:32]);
		end
	end

endmodule

@@ rtl/tac_recip.sv @@
// Restoring divider: floor(2^72 / m), one quotient bit per pipeline stage.
module tac_recip import tac_pkg::*; #(
	parameter int M_W = INVM_W,
	parameter int Q_W = DIV_Q_W
) (
	input  logic           clk,
	input  logic           en,
	input  logic [M_W-1:0] m,
	output logic [Q_W-1:0] q
);

	localparam int RW     = M_W + 1;
	localparam int R0_EXP = DIV_NUM_EXP - Q_W;

	logic [RW-1:0]  r_s [Q_W];
	logic [M_W-1:0] m_s [Q_W];
	logic [Q_W-1:0] q_s [Q_W];

	for (genvar g = 0; g < Q_W; g++) begin : g_bit
		logic [RW-1:0]  r_prev;
		logic [RW-1:0]  r_dbl;
		logic [M_W-1:0] m_prev;
		logic [Q_W-1:0] q_prev;

		if (g == 0) begin : g_first
			// partial remainder after the leading dividend bits that give no quotient bit
			assign r_prev = RW'(1) << R0_EXP;
			assign m_prev = m;
			assign q_prev = '0;
		end else begin : g_next
			assign r_prev = r_s[g-1];
			assign m_prev = m_s[g-1];
			assign q_prev = q_s[g-1];
		end

		assign r_dbl = r_prev << 1;

		always_ff @(posedge clk) begin
			if (en) begin
				m_s[g] <= m_prev;
				if (r_dbl >= RW'(m_prev)) begin
					r_s[g] <= r_dbl - RW'(m_prev);
					q_s[g] <= {q_prev[Q_W-2:0], 1'b1};
				end else begin
					r_s[g] <= r_dbl;
					q_s[g] <= {q_prev[Q_W-2:0], 1'b0};
				end
			end
		end
	end

	assign q = q_s[Q_W-1];

endmodule

@@ rtl/thermistor_adc_to_celsius_unit.sv @@
// One item per cycle is accepted while the skid stage is empty.
// The depth is set by the 32 log squaring stages and the 41 reciprocal quotient stages.
// An output register plus a skid stage keep ready registered; the whole pipe freezes once the skid stage holds an item.
// Reset (arst_n, async, active low) empties the pipeline and loads the register defaults.
module thermistor_adc_to_celsius_unit import tac_pkg::*; #(
	parameter int ADC_BITS = ADC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wr_data,
	tac_code_if.sink              sample,
	tac_temp_if.source            result
);

	localparam logic [ADC_BITS-1:0] FULL_CODE = '1;
	localparam int FRONT_LEN = LN_LAT + 3*MUL_LAT + 5;

	// ---------------------------------------------------------------- registers
	logic [COEF_W-1:0] coef_a_q;
	logic [COEF_W-1:0] coef_b_q;
	logic [COEF_W-1:0] coef_c_q;
	logic [SR_W-1:0]   sr_q;
	logic [TEMP_W-1:0] default_temp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a_q       <= COEF_A_RST;
			coef_b_q       <= COEF_B_RST;
			coef_c_q       <= COEF_C_RST;
			sr_q           <= SERIES_RES_RST;
			default_temp_q <= DEFAULT_TEMP_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_COEF_A:       coef_a_q       <= cfg_wr_data[COEF_W-1:0];
				REG_COEF_B:       coef_b_q       <= cfg_wr_data[COEF_W-1:0];
				REG_COEF_C:       coef_c_q       <= cfg_wr_data[COEF_W-1:0];
				REG_SERIES_RES:   sr_q           <= cfg_wr_data[SR_W-1:0];
				REG_DEFAULT_TEMP: default_temp_q <= cfg_wr_data[TEMP_W-1:0];
				default: ;
			endcase
		end
	end

	// The whole pipeline advances unless the skid stage is holding an item.
	logic skid_valid_q;
	logic en;

	assign en           = !skid_valid_q;
	assign sample.ready = en;

	// ---------------------------------------------------------------- input stage
	front_ctl_t          ctl_s1;
	logic [ADC_BITS-1:0] code_s1;
	logic                rail_in;

	// Codes at either rail, or no series resistor, take the default temperature.
	assign rail_in = (sample.adc_code == '0) || (sample.adc_code == FULL_CODE) || (sr_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1.valid <= sample.valid;
			ctl_s1.rail  <= rail_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) code_s1 <= sample.adc_code;
	end

	// ---------------------------------------------------------------- logs
	// lnR = ln(Rs) + ln(F - c) - ln(c); the supply voltage drops out.
	logic [LN_W-1:0] ln_sr;
	logic [LN_W-1:0] ln_hi;
	logic [LN_W-1:0] ln_lo;

	tac_ln #(.IN_W(SR_W)) u_ln_sr (
		.clk (clk), .en (en), .x (sr_q), .ln (ln_sr)
	);

	tac_ln #(.IN_W(ADC_BITS)) u_ln_hi (
		.clk (clk), .en (en), .x (FULL_CODE - code_s1), .ln (ln_hi)
	);

	tac_ln #(.IN_W(ADC_BITS)) u_ln_lo (
		.clk (clk), .en (en), .x (code_s1), .ln (ln_lo)
	);

	logic signed [Y_W-1:0] y_s2;
	logic [YM_W-1:0]       ymag_s3;
	logic                  yneg_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			y_s2    <= $signed(Y_W'(ln_sr) + Y_W'(ln_hi) - Y_W'(ln_lo));
			ymag_s3 <= y_s2[Y_W-1] ? YM_W'(-y_s2) : YM_W'(y_s2);
			yneg_s3 <= y_s2[Y_W-1];
		end
	end

	// ---------------------------------------------------------------- polynomial
	// All products work on magnitudes and truncate toward zero; signs ride alongside.
	logic              b_neg;
	logic              c_neg;
	logic [COEF_W-1:0] b_mag;
	logic [COEF_W-1:0] c_mag;

	assign b_neg = coef_b_q[COEF_W-1];
	assign c_neg = coef_c_q[COEF_W-1];
	assign b_mag = b_neg ? -coef_b_q : coef_b_q;
	assign c_mag = c_neg ? -coef_c_q : coef_c_q;

	logic [2*YM_W-1:0]      p_yy;
	logic [COEF_W+YM_W-1:0] p_by;
	logic [Y2_W+YM_W-1:0]   p_y3;
	logic [COEF_W+Y3_W-1:0] p_cy;
	logic [YM_W-1:0]        ymag_d;
	logic [PB_W-1:0]        pb_d;
	logic                   yneg_d;
	logic [Y2_W-1:0]        y2;
	logic [Y3_W-1:0]        y3;

	tac_mul #(.WA(YM_W), .WB(YM_W)) u_mul_yy (
		.clk (clk), .en (en), .a (ymag_s3), .b (ymag_s3), .p (p_yy)
	);

	tac_mul #(.WA(COEF_W), .WB(YM_W)) u_mul_by (
		.clk (clk), .en (en), .a (b_mag), .b (ymag_s3), .p (p_by)
	);

	tac_delay #(.W(YM_W), .N(MUL_LAT)) u_dly_ymag (
		.clk (clk), .arst_n (arst_n), .en (en), .d (ymag_s3), .q (ymag_d)
	);

	assign y2 = p_yy[32 +: Y2_W];

	tac_mul #(.WA(Y2_W), .WB(YM_W)) u_mul_y3 (
		.clk (clk), .en (en), .a (y2), .b (ymag_d), .p (p_y3)
	);

	assign y3 = p_y3[32 +: Y3_W];

	tac_mul #(.WA(COEF_W), .WB(Y3_W)) u_mul_cy (
		.clk (clk), .en (en), .a (c_mag), .b (y3), .p (p_cy)
	);

	tac_delay #(.W(PB_W), .N(2*MUL_LAT)) u_dly_pb (
		.clk (clk), .arst_n (arst_n), .en (en), .d (p_by[24 +: PB_W]), .q (pb_d)
	);

	tac_delay #(.W(1), .N(3*MUL_LAT)) u_dly_yneg (
		.clk (clk), .arst_n (arst_n), .en (en), .d (yneg_s3), .q (yneg_d)
	);

	logic signed [INV_W-1:0] tb_s4;
	logic signed [INV_W-1:0] tc_s4;
	logic signed [INV_W-1:0] inv_s5;
	logic [INVM_W-1:0]       inv_mag;
	logic [INVM_W-1:0]       invmag_s6;
	logic                    inv_neg_s6;
	logic                    tiny_s6;

	// inverse temperature in Q56: A*256 + B*lnR + C*lnR^3
	assign inv_mag = inv_s5[INV_W-1] ? INVM_W'(-inv_s5) : INVM_W'(inv_s5);

	always_ff @(posedge clk) begin
		if (en) begin
			tb_s4      <= (b_neg ^ yneg_d) ? -$signed(INV_W'(pb_d)) : $signed(INV_W'(pb_d));
			tc_s4      <= (c_neg ^ yneg_d) ? -$signed(INV_W'(p_cy[40 +: PC_W]))
				: $signed(INV_W'(p_cy[40 +: PC_W]));
			inv_s5     <= $signed({{(INV_W-COEF_W-8){coef_a_q[COEF_W-1]}}, coef_a_q, 8'b0})
				+ tb_s4 + tc_s4;
			invmag_s6  <= inv_mag;
			inv_neg_s6 <= inv_s5[INV_W-1];
			tiny_s6    <= (inv_mag[INVM_W-1:32] == '0);
		end
	end

	// ---------------------------------------------------------------- reciprocal
	front_ctl_t           ctl_d;
	back_ctl_t            bctl_in;
	back_ctl_t            bctl_d;
	logic [DIV_Q_W-1:0]   kelvin_q;

	tac_delay #(.W($bits(front_ctl_t)), .N(FRONT_LEN)) u_dly_front (
		.clk (clk), .arst_n (arst_n), .en (en), .d (ctl_s1), .q (ctl_d)
	);

	assign bctl_in.valid = ctl_d.valid;
	assign bctl_in.rail  = ctl_d.rail;
	assign bctl_in.neg   = inv_neg_s6;
	assign bctl_in.tiny  = tiny_s6;

	tac_delay #(.W($bits(back_ctl_t)), .N(DIV_Q_W)) u_dly_back (
		.clk (clk), .arst_n (arst_n), .en (en), .d (bctl_in), .q (bctl_d)
	);

	tac_recip #(.M_W(INVM_W), .Q_W(DIV_Q_W)) u_recip (
		.clk (clk), .en (en), .m (invmag_s6), .q (kelvin_q)
	);

	// ---------------------------------------------------------------- Celsius and clipping
	back_ctl_t               ctl_s7;
	logic signed [T16_W-1:0] t16_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s7 <= '0;
		end else if (en) begin
			ctl_s7 <= bctl_d;
		end
	end

	// Kelvin Q16 minus 273.15, plus half an output step before the floor shift
	always_ff @(posedge clk) begin
		if (en) begin
			t16_s7 <= (bctl_d.neg ? -$signed(T16_W'(kelvin_q)) : $signed(T16_W'(kelvin_q)))
				- T16_W'(ZERO_C_Q16) + T16_W'(128);
		end
	end

	logic signed [T8_W-1:0]   t8;
	logic signed [TEMP_W-1:0] temp_nx;
	logic [STATUS_W-1:0]      status_nx;

	assign t8 = T8_W'(t16_s7 >>> 8);

	always_comb begin
		priority if (ctl_s7.rail) begin
			temp_nx   = $signed(default_temp_q);
			status_nx = STATUS_RAIL;
		end else if (ctl_s7.tiny) begin
			temp_nx   = ctl_s7.neg ? TEMP_W'(TEMP_MIN_V) : TEMP_W'(TEMP_MAX_V);
			status_nx = STATUS_SAT;
		end else if (t8 > T8_W'(TEMP_MAX_V)) begin
			temp_nx   = TEMP_W'(TEMP_MAX_V);
			status_nx = STATUS_SAT;
		end else if (t8 < T8_W'(TEMP_MIN_V)) begin
			temp_nx   = TEMP_W'(TEMP_MIN_V);
			status_nx = STATUS_SAT;
		end else begin
			temp_nx   = t8[TEMP_W-1:0];
			status_nx = STATUS_OK;
		end
	end

	logic                     valid_s8;
	logic signed [TEMP_W-1:0] temp_s8;
	logic [STATUS_W-1:0]      status_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s8 <= 1'b0;
		end else if (en) begin
			valid_s8 <= ctl_s7.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			temp_s8   <= temp_nx;
			status_s8 <= status_nx;
		end
	end

	// ---------------------------------------------------------------- output and skid
	// The skid stage catches the item leaving the pipe while the output is stalled.
	logic                     res_valid_q;
	logic signed [TEMP_W-1:0] res_temp_q;
	logic [STATUS_W-1:0]      res_status_q;
	logic signed [TEMP_W-1:0] skid_temp_q;
	logic [STATUS_W-1:0]      skid_status_q;
	logic                     from_skid;
	logic                     load_res;
	logic                     load_skid;

	assign from_skid = skid_valid_q && result.ready;
	assign load_res  = !skid_valid_q && valid_s8 && (!res_valid_q || result.ready);
	assign load_skid = !skid_valid_q && valid_s8 && res_valid_q && !result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (from_skid) skid_valid_q <= 1'b0;
			else if (load_skid) skid_valid_q <= 1'b1;
			if (load_res) res_valid_q <= 1'b1;
			else if (!skid_valid_q && result.ready) res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (from_skid) begin
			res_temp_q   <= skid_temp_q;
			res_status_q <= skid_status_q;
		end else if (load_res) begin
			res_temp_q   <= temp_s8;
			res_status_q <= status_s8;
		end
		if (load_skid) begin
			skid_temp_q   <= temp_s8;
			skid_status_q <= status_s8;
		end
	end

	assign result.valid       = res_valid_q;
	assign result.temperature = res_temp_q;
	assign result.status      = res_status_q;

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the thermistor divider to Celsius pipeline.
module tb import tac_pkg::*;;

	localparam int  FULL_CODE  = (1 << ADC_BITS_DEF) - 1;
	localparam int  HOLD_CYCLES = 300;
	localparam int  DRAIN_CYCLES = 100;
	localparam longint CYCLE_LIMIT = 400000;
	localparam int  DIRECTED_CODES [12] = '{0, 1, 2, 511, 512, 682, 341, 1021, 1022, 1023,
		100, 900};

	typedef struct packed {
		logic signed [TEMP_W-1:0] temperature;
		logic [STATUS_W-1:0]      status;
	} reading_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_COEF_A;
	logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

	tac_code_if #(.ADC_BITS(ADC_BITS_DEF)) sample ();
	tac_temp_if result ();

	thermistor_adc_to_celsius_unit #(.ADC_BITS(ADC_BITS_DEF)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wr_data(cfg_wr_data),
		.sample(sample.sink),
		.result(result.source)
	);

	always #1 clk = ~clk;

	// Shadow copy of the register file, updated whenever the test has written a register set.
	logic [COEF_W-1:0] sh_coef_a = COEF_A_RST;
	logic [COEF_W-1:0] sh_coef_b = COEF_B_RST;
	logic [COEF_W-1:0] sh_coef_c = COEF_C_RST;
	logic [SR_W-1:0]   sh_series = SERIES_RES_RST;
	logic [TEMP_W-1:0] sh_default = DEFAULT_TEMP_RST;

	logic [ADC_BITS_DEF-1:0] pending_codes[$];
	reading_t expected_readings[$];

	int  mismatches = 0;
	logic quiet = 1'b0;      // no idling on either side when set
	logic hold_req = 1'b0;   // ask the receiver for one long hold-off
	logic hold_done = 1'b0;
	longint cycles = 0;

	// append one code to the tail of the stimulus queue
	function automatic void add_code(logic [ADC_BITS_DEF-1:0] code);
		pending_codes.insert(pending_codes.size(), code);
	endfunction

	// natural log in Q32 by normalization and repeated squaring
	function automatic logic [63:0] ln_fixed(logic [63:0] x);
		int k;
		logic [63:0] m;
		logic [63:0] frac;
		k = 0;
		frac = '0;
		while (k < 30 && (x >> (k + 1)) != 0)
			k++;
		m = (x << (30 - k)) & 64'hFFFF_FFFF;
		for (int i = 0; i < 32; i++) begin
			m = (m * m) >> 30;
			frac = frac << 1;
			if (m >= (64'd1 << 31)) begin
				m = m >> 1;
				frac = frac | 64'd1;
			end
		end
		return 64'(k) * 64'(LN2_Q32) + ((frac * 64'(LN2_Q32)) >> 32);
	endfunction

	// exact signed product, magnitude truncated after the shift
	function automatic longint scaled_product(longint a, longint b, int s);
		logic [63:0] ua;
		logic [63:0] ub;
		logic [127:0] p;
		logic [63:0] r;
		ua = a;
		ub = b;
		if (a < 0) ua = -ua;
		if (b < 0) ub = -ub;
		p = {64'd0, ua} * {64'd0, ub};
		r = 64'(p >> s) & 64'h7FFF_FFFF_FFFF_FFFF;
		return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
	endfunction

	function automatic reading_t celsius_of(logic [ADC_BITS_DEF-1:0] code);
		reading_t rd;
		longint y;
		longint y2;
		longint y3;
		longint inv;
		longint t16;
		longint t8;
		logic [63:0] m;
		logic [127:0] q;
		if (code == 0 || code >= FULL_CODE || sh_series == 0) begin
			rd.temperature = sh_default;
			rd.status = STATUS_RAIL;
			return rd;
		end
		y = longint'(ln_fixed(64'(sh_series))) + longint'(ln_fixed(64'(FULL_CODE - code)))
			- longint'(ln_fixed(64'(code)));
		y2 = scaled_product(y, y, 32);
		y3 = scaled_product(y2, y, 32);
		inv = longint'($signed(sh_coef_a)) * 256
			+ scaled_product(longint'($signed(sh_coef_b)), y, 24)
			+ scaled_product(longint'($signed(sh_coef_c)), y3, 40);
		m = inv;
		if (inv < 0) m = -m;
		rd.status = STATUS_OK;
		if (m < (64'd1 << 32)) begin
			t8 = (inv < 0) ? TEMP_MIN_V : TEMP_MAX_V;
			rd.status = STATUS_SAT;
		end else begin
			q = (128'd1 << DIV_NUM_EXP) / {64'd0, m};
			t16 = ((inv < 0) ? -longint'(q) : longint'(q)) - ZERO_C_Q16 + 128;
			t8 = t16 >>> 8;
			if (t8 > TEMP_MAX_V) begin
				t8 = TEMP_MAX_V;
				rd.status = STATUS_SAT;
			end else if (t8 < TEMP_MIN_V) begin
				t8 = TEMP_MIN_V;
				rd.status = STATUS_SAT;
			end
		end
		rd.temperature = t8[TEMP_W-1:0];
		return rd;
	endfunction

	// Driver: hold an offered item until taken, then advance or insert a gap.
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample.valid <= 1'b0;
			sample.adc_code <= '0;
			gap_left = 0;
		end else begin
			if (sample.valid && sample.ready)
				expected_readings.insert(expected_readings.size(),
					celsius_of(sample.adc_code));
			if (sample.valid && !sample.ready) begin
				// hold the current item
			end else if (gap_left > 0) begin
				gap_left--;
				sample.valid <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				gap_left = $urandom_range(1, 12) - 1;
				sample.valid <= 1'b0;
			end else if (pending_codes.size() > 0) begin
				sample.valid <= 1'b1;
				sample.adc_code <= pending_codes.pop_front();
			end else begin
				sample.valid <= 1'b0;
			end
		end
	end

	// Monitor: check each taken result against the oldest expectation, drive stalls.
	int stall_left = 0;
	always @(posedge clk or negedge arst_n) begin
		reading_t want;
		if (!arst_n) begin
			result.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (result.valid && result.ready) begin
				if (expected_readings.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result temperature=%0d status=%0d",
							result.temperature, result.status);
				end else begin
					want = expected_readings.pop_front();
					if (result.temperature !== want.temperature || result.status !== want.status) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected temp=%0d status=%0d, got temp=%0d status=%0d",
								want.temperature, want.status, result.temperature, result.status);
					end
				end
			end
			if (hold_req && !hold_done) begin
				// long hold-off so the pipeline fills and backs up into the input
				hold_done <= 1'b1;
				stall_left = HOLD_CYCLES;
				result.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				result.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 12) - 1;
				result.ready <= 1'b0;
			end else begin
				result.ready <= 1'b1;
			end
		end
	end

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Write a whole register set back to back, then drop the enable.
	task automatic load_regs(logic [COEF_W-1:0] a, logic [COEF_W-1:0] b, logic [COEF_W-1:0] c,
			logic [SR_W-1:0] sr, logic [TEMP_W-1:0] dflt);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_COEF_A;
		cfg_wr_data <= a;
		@(posedge clk);
		cfg_index <= REG_COEF_B;
		cfg_wr_data <= b;
		@(posedge clk);
		cfg_index <= REG_COEF_C;
		cfg_wr_data <= c;
		@(posedge clk);
		cfg_index <= REG_SERIES_RES;
		cfg_wr_data <= {{(CFG_DATA_W-SR_W){1'b0}}, sr};
		@(posedge clk);
		cfg_index <= REG_DEFAULT_TEMP;
		cfg_wr_data <= {{(CFG_DATA_W-TEMP_W){1'b0}}, dflt};
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sh_coef_a = a;
		sh_coef_b = b;
		sh_coef_c = c;
		sh_series = sr;
		sh_default = dflt;
	endtask

	// Wait until every queued code has gone in and every result has come out.
	// Sample on the falling edge, after the driver's updates have settled.
	task automatic wait_drained();
		while (pending_codes.size() > 0 || sample.valid || expected_readings.size() > 0)
			@(negedge clk);
	endtask

	function automatic logic [ADC_BITS_DEF-1:0] pick_code();
		case ($urandom_range(0, 19))
			0: return '0;
			1: return ADC_BITS_DEF'(FULL_CODE);
			2: return ADC_BITS_DEF'(1);
			3: return ADC_BITS_DEF'(FULL_CODE - 1);
			default: return ADC_BITS_DEF'($urandom_range(0, FULL_CODE));
		endcase
	endfunction

	function automatic logic [COEF_W-1:0] nudge(logic [COEF_W-1:0] base);
		// scale by roughly +-1/16 so the curve stays physical
		longint v;
		v = longint'($signed(base));
		return COEF_W'(v + (v >>> 4) * (longint'($urandom_range(0, 64)) - 32) / 32);
	endfunction

	function automatic logic [COEF_W-1:0] any_coef();
		return {16'($urandom), 32'($urandom)};
	endfunction

	localparam logic [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
	localparam logic [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

	initial begin
		logic [COEF_W-1:0] a;
		logic [COEF_W-1:0] b;
		logic [COEF_W-1:0] c;
		logic [SR_W-1:0] sr;
		logic [TEMP_W-1:0] dflt;
		int phases;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset registers, both rails, ends and alternating bit patterns.
		foreach (DIRECTED_CODES[i])
			add_code(ADC_BITS_DEF'(DIRECTED_CODES[i]));
		wait_drained();

		// Zero series resistance behaves as a rail; extreme default temperature.
		load_regs(COEF_A_RST, COEF_B_RST, COEF_C_RST, '0, {1'b1, {(TEMP_W-1){1'b0}}});
		add_code(10'd512);
		add_code(10'd0);
		wait_drained();
		// All coefficients zero: inverse near zero saturates high.
		load_regs('0, '0, '0, {SR_W{1'b1}}, {1'b0, {(TEMP_W-1){1'b1}}});
		add_code(10'd512);
		add_code(10'd1);
		add_code(10'd1023);
		wait_drained();
		// Negative inverse gives a Kelvin value below zero; largest coefficients, smallest resistance.
		load_regs(COEF_MIN, '0, '0, 24'd1, DEFAULT_TEMP_RST);
		add_code(10'd512);
		wait_drained();
		load_regs(COEF_MAX, COEF_MAX, COEF_MAX, 24'd1, DEFAULT_TEMP_RST);
		add_code(10'd1);
		add_code(10'd1022);
		wait_drained();
		load_regs(COEF_MIN, COEF_MIN, COEF_MIN, {SR_W{1'b1}}, '0);
		add_code(10'd1);
		add_code(10'd1022);
		add_code(10'd512);
		wait_drained();

		// Random phases: mostly physical curves, some wild coefficient sets.
		phases = 11;
		for (int p = 0; p < phases; p++) begin
			if ($urandom_range(0, 3) == 0) begin
				a = any_coef();
				b = any_coef();
				c = any_coef();
			end else begin
				a = nudge(COEF_A_RST);
				b = nudge(COEF_B_RST);
				c = ($urandom_range(0, 3) == 0) ? '0 : nudge(COEF_C_RST);
			end
			case ($urandom_range(0, 5))
				0: sr = SR_W'($urandom_range(0, 3));
				1: sr = {SR_W{1'b1}} - SR_W'($urandom_range(0, 3));
				2: sr = SR_W'($urandom);
				default: sr = SR_W'($urandom_range(1000, 100000));
			endcase
			dflt = TEMP_W'($urandom);
			load_regs(a, b, c, sr, dflt);
			if (p == phases - 1)
				quiet = 1'b1;
			for (int i = 0; i < 150; i++)
				add_code(pick_code());
			if (p == 2)
				hold_req = 1'b1;
			// sender pauses here until every result is back
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_readings.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
